[src/grc_pkg.sv]
// shared types, constants and functions of the grid raycast column unit
`default_nettype none

package grc_pkg;

	// map geometry
	localparam int MAP_SIZE_DEF = 16;
	localparam int POS_UNIT     = 163840;

	// shared restoring divider
	localparam int DIV_STEPS = 26;

	// configuration register indexes and reset values
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FOV    = 2'd2;
	localparam logic [1:0] CFG_STEPS  = 2'd3;

	localparam logic [9:0]  WIDTH_RST  = 10'd120;
	localparam logic [7:0]  HEIGHT_RST = 8'd40;
	localparam logic [15:0] FOV_RST    = 16'd8192;
	localparam logic [7:0]  STEPS_RST  = 8'd160;

	// shade codes
	localparam logic [2:0] SHADE_FULL   = 3'd0;
	localparam logic [2:0] SHADE_DARK   = 3'd1;
	localparam logic [2:0] SHADE_MEDIUM = 3'd2;
	localparam logic [2:0] SHADE_LIGHT  = 3'd3;
	localparam logic [2:0] SHADE_BLANK  = 3'd4;

	// datapath operations
	localparam logic [4:0] OP_NONE    = 5'd0;
	localparam logic [4:0] OP_LATCH   = 5'd1;
	localparam logic [4:0] OP_OFF_MUL = 5'd2;
	localparam logic [4:0] OP_DIV     = 5'd3;
	localparam logic [4:0] OP_ANGLE   = 5'd4;
	localparam logic [4:0] OP_TRIG_T  = 5'd5;
	localparam logic [4:0] OP_TRIG_R  = 5'd6;
	localparam logic [4:0] OP_TRIG_S  = 5'd7;
	localparam logic [4:0] OP_M_INIT  = 5'd8;
	localparam logic [4:0] OP_MARCH   = 5'd9;
	localparam logic [4:0] OP_CRN_X   = 5'd10;
	localparam logic [4:0] OP_CRN_Y   = 5'd11;
	localparam logic [4:0] OP_DOT_A   = 5'd12;
	localparam logic [4:0] OP_DOT_B   = 5'd13;
	localparam logic [4:0] OP_CRS_A   = 5'd14;
	localparam logic [4:0] OP_CRS_B   = 5'd15;
	localparam logic [4:0] OP_SQ_D    = 5'd16;
	localparam logic [4:0] OP_SQ_C    = 5'd17;
	localparam logic [4:0] OP_SCALE   = 5'd18;
	localparam logic [4:0] OP_CMP     = 5'd19;
	localparam logic [4:0] OP_CEIL    = 5'd20;
	localparam logic [4:0] OP_FINISH  = 5'd21;

	// sine polynomial seed
	localparam logic [31:0] SINE_SEED = 32'd172271;

	typedef struct packed {
		logic        action;
		logic [3:0]  row_index;
		logic [15:0] row_walls;
		logic [9:0]  column;
		logic [15:0] player_x;
		logic [15:0] player_y;
		logic [15:0] player_angle;
	} item_t;

	typedef struct packed {
		logic [9:0] cast_column;
		logic [7:0] distance_steps;
		logic [6:0] ceiling_row;
		logic [7:0] floor_row;
		logic [2:0] wall_shade;
		logic       corner_edge;
		logic       left_map;
	} result_t;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] idx;
		logic       sel;
	} cmd_t;

	typedef struct packed {
		logic march_off;
		logic march_hit;
		logic march_last;
	} status_t;

	// horner coefficients of the quarter-wave sine, Q30
	function automatic logic [31:0] poly_coef(input logic [1:0] i);
		logic [31:0] c;
		case (i)
			2'd0:    c = 32'd5026994;
			2'd1:    c = 32'd85569306;
			2'd2:    c = 32'd693598669;
			default: c = 32'd1686629713;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[src/grc_ctrl.sv]
// sequencing state machine of the grid raycast column unit
`default_nettype none

module grc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_cast,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  grc_pkg::status_t status,
	output grc_pkg::cmd_t    cmd
);
	import grc_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_OFFMUL = 5'd1;
	localparam logic [4:0] S_DIVOFF = 5'd2;
	localparam logic [4:0] S_ANGLE  = 5'd3;
	localparam logic [4:0] S_TRIGT  = 5'd4;
	localparam logic [4:0] S_TRIGR  = 5'd5;
	localparam logic [4:0] S_TRIGS  = 5'd6;
	localparam logic [4:0] S_MINIT  = 5'd7;
	localparam logic [4:0] S_MARCH  = 5'd8;
	localparam logic [4:0] S_CRNX   = 5'd9;
	localparam logic [4:0] S_CRNY   = 5'd10;
	localparam logic [4:0] S_DOTA   = 5'd11;
	localparam logic [4:0] S_DOTB   = 5'd12;
	localparam logic [4:0] S_CRSA   = 5'd13;
	localparam logic [4:0] S_CRSB   = 5'd14;
	localparam logic [4:0] S_SQD    = 5'd15;
	localparam logic [4:0] S_SQC    = 5'd16;
	localparam logic [4:0] S_SCALE  = 5'd17;
	localparam logic [4:0] S_CMP    = 5'd18;
	localparam logic [4:0] S_CEIL   = 5'd19;
	localparam logic [4:0] S_DIVC   = 5'd20;
	localparam logic [4:0] S_FIN    = 5'd21;

	localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

	logic [4:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       sel_q, sel_d;
	logic       out_valid_q;
	logic       fin_go;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign fin_go       = (state_q == S_FIN) && (!out_valid_q || result_ready);

	// next state and operation
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		sel_d   = sel_q;
		cmd.op  = OP_NONE;
		cmd.idx = cnt_q[1:0];
		cmd.sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.op = OP_LATCH;
					if (item_cast) state_d = S_OFFMUL;
				end
			end
			S_OFFMUL: begin
				cmd.op  = OP_OFF_MUL;
				cnt_d   = '0;
				state_d = S_DIVOFF;
			end
			S_DIVOFF: begin
				cmd.op = OP_DIV;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_ANGLE;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_ANGLE: begin
				cmd.op  = OP_ANGLE;
				sel_d   = 1'b0;
				state_d = S_TRIGT;
			end
			S_TRIGT: begin
				cmd.op  = OP_TRIG_T;
				cnt_d   = '0;
				state_d = S_TRIGR;
			end
			S_TRIGR: begin
				cmd.op = OP_TRIG_R;
				if (cnt_q[1:0] == 2'd3) state_d = S_TRIGS;
				cnt_d = cnt_q + 5'd1;
			end
			S_TRIGS: begin
				cmd.op = OP_TRIG_S;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = S_TRIGT;
				end else begin
					state_d = S_MINIT;
				end
			end
			S_MINIT: begin
				cmd.op  = OP_M_INIT;
				state_d = S_MARCH;
			end
			S_MARCH: begin
				cmd.op = OP_MARCH;
				if (status.march_off) begin
					state_d = S_CEIL;
				end else if (status.march_hit) begin
					cnt_d   = '0;
					state_d = S_CRNX;
				end else if (status.march_last) begin
					state_d = S_CEIL;
				end
			end
			S_CRNX: begin
				cmd.op  = OP_CRN_X;
				state_d = S_CRNY;
			end
			S_CRNY: begin
				cmd.op = OP_CRN_Y;
				if (cnt_q[1:0] == 2'd3) begin
					sel_d   = 1'b0;
					state_d = S_DOTA;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = S_CRNX;
				end
			end
			S_DOTA: begin
				cmd.op  = OP_DOT_A;
				state_d = S_DOTB;
			end
			S_DOTB: begin
				cmd.op  = OP_DOT_B;
				state_d = S_CRSA;
			end
			S_CRSA: begin
				cmd.op  = OP_CRS_A;
				state_d = S_CRSB;
			end
			S_CRSB: begin
				cmd.op  = OP_CRS_B;
				state_d = S_SQD;
			end
			S_SQD: begin
				cmd.op  = OP_SQ_D;
				state_d = S_SQC;
			end
			S_SQC: begin
				cmd.op  = OP_SQ_C;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.op  = OP_SCALE;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op = OP_CMP;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = S_DOTA;
				end else begin
					state_d = S_CEIL;
				end
			end
			S_CEIL: begin
				cmd.op  = OP_CEIL;
				cnt_d   = '0;
				state_d = S_DIVC;
			end
			S_DIVC: begin
				cmd.op = OP_DIV;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[src/grc_datapath.sv]
// arithmetic, wall map and result register of the grid raycast column unit
`default_nettype none

module grc_datapath #(
	parameter int MAP_SIZE = grc_pkg::MAP_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  grc_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  grc_pkg::cmd_t    cmd,
	output grc_pkg::status_t status,
	output grc_pkg::result_t result
);
	import grc_pkg::*;

	localparam int IW        = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
	localparam int PW        = 25;
	localparam int POS_LIMIT = MAP_SIZE * POS_UNIT;

	// configuration and map
	logic [9:0]          width_q;
	logic [7:0]          height_q;
	logic [15:0]         fov_q;
	logic [7:0]          steps_q;
	logic [MAP_SIZE-1:0] map_q [MAP_SIZE];

	// item and working registers
	logic [9:0]         col_q;
	logic [15:0]        px_q, py_q, pa_q, ang_q;
	logic [14:0]        t_q;
	logic               neg_q;
	logic [30:0]        u2_q;
	logic [31:0]        r_q;
	logic signed [15:0] ex_q, ey_q;
	logic signed [PW-1:0] xp_q, yp_q;
	logic [7:0]         k_q, dist_q;
	logic               off_q, corner_q;
	logic [IW-1:0]      cx_q, cy_q;
	logic signed [17:0] ay_q;
	logic signed [39:0] acc_q, dot_q, crs_q;
	logic signed [17:0] n0x_q, n0y_q, n1x_q, n1y_q;
	logic [35:0]        n0d_q, n1d_q;
	logic [51:0]        sqd_q, sqc_q;
	logic [53:0]        scd_q;
	logic [66:0]        scc_q;
	logic [25:0]        quo_q;
	logic [10:0]        rem_q, dvs_q;
	result_t            res_q;

	// effective width and depth limit
	logic [9:0] w_eff;
	logic [7:0] lim_eff;
	assign w_eff   = (width_q == '0) ? 10'd1 : width_q;
	assign lim_eff = (steps_q == '0) ? 8'd1 : steps_q;

	// divider step
	logic [11:0] rem_sh;
	logic        div_ge;
	logic [10:0] rem_n;
	assign rem_sh = {rem_q, quo_q[25]};
	assign div_ge = rem_sh >= {1'b0, dvs_q};
	assign rem_n  = div_ge ? 11'(rem_sh - {1'b0, dvs_q}) : rem_sh[10:0];

	// quarter-wave argument
	logic [14:0] t_c;
	always_comb begin
		if (ang_q[14]) t_c = 15'(15'd16384 - {1'b0, ang_q[13:0]});
		else           t_c = {1'b0, ang_q[13:0]};
	end

	// march cell lookup
	logic [7:0]  vx8, vy8;
	logic [15:0] cxp, cyp;
	logic [IW-1:0] cx_c, cy_c;
	logic [MAP_SIZE-1:0] row_c;
	logic        off_c, wall_c;
	assign off_c = xp_q[PW-1] || yp_q[PW-1] ||
		(xp_q >= PW'(POS_LIMIT)) || (yp_q >= PW'(POS_LIMIT));
	assign vx8   = xp_q[22:15];
	assign vy8   = yp_q[22:15];
	assign cxp   = 16'(vx8) * 16'd205;
	assign cyp   = 16'(vy8) * 16'd205;
	assign cx_c  = cxp[IW+9:10];
	assign cy_c  = cyp[IW+9:10];
	assign row_c = map_q[cy_c];
	assign wall_c = row_c[cx_c];

	assign status.march_off  = off_c;
	assign status.march_hit  = !off_c && wall_c;
	assign status.march_last = (k_q == lim_eff);

	// corner vector of the current corner
	logic [IW:0]        sx, sy;
	logic signed [17:0] ax_c, ay_c;
	assign sx   = {1'b0, cx_q} + (IW+1)'(cmd.idx[1]);
	assign sy   = {1'b0, cy_q} + (IW+1)'(cmd.idx[0]);
	assign ax_c = $signed(18'({sx, 12'b0})) - $signed(18'(px_q));
	assign ay_c = $signed(18'({sy, 12'b0})) - $signed(18'(py_q));

	logic signed [17:0] vx_sel, vy_sel;
	assign vx_sel = cmd.sel ? n1x_q : n0x_q;
	assign vy_sel = cmd.sel ? n1y_q : n0y_q;

	logic signed [39:0] crs_abs;
	assign crs_abs = crs_q[39] ? -crs_q : crs_q;

	// shared multiplier
	logic signed [33:0] ma, mb;
	logic signed [67:0] mp;
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_OFF_MUL: begin
				ma = $signed(34'(col_q));
				mb = $signed(34'(fov_q));
			end
			OP_TRIG_T: begin
				ma = $signed(34'(t_c));
				mb = $signed(34'(t_c));
			end
			OP_TRIG_R: begin
				ma = $signed(34'(u2_q));
				mb = $signed(34'((cmd.idx == 2'd0) ? SINE_SEED : r_q));
			end
			OP_TRIG_S: begin
				ma = $signed(34'(t_q));
				mb = $signed(34'(r_q));
			end
			OP_CRN_X: begin
				ma = 34'(ax_c);
				mb = 34'(ax_c);
			end
			OP_CRN_Y: begin
				ma = 34'(ay_q);
				mb = 34'(ay_q);
			end
			OP_DOT_A: begin
				ma = 34'(ex_q);
				mb = 34'(vx_sel);
			end
			OP_DOT_B: begin
				ma = 34'(ey_q);
				mb = 34'(vy_sel);
			end
			OP_CRS_A: begin
				ma = 34'(ex_q);
				mb = 34'(vy_sel);
			end
			OP_CRS_B: begin
				ma = 34'(ey_q);
				mb = 34'(vx_sel);
			end
			OP_SQ_D: begin
				ma = $signed(34'(dot_q[32:7]));
				mb = $signed(34'(dot_q[32:7]));
			end
			OP_SQ_C: begin
				ma = $signed(34'(crs_abs[32:7]));
				mb = $signed(34'(crs_abs[32:7]));
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mp = ma * mb;

	// sine rounding, cap and sign
	logic [33:0]        s_rnd;
	logic [17:0]        s_mag;
	logic [14:0]        s_cap;
	logic signed [15:0] s_val;
	assign s_rnd = {1'b0, mp[46:14]} + 34'd32768;
	assign s_mag = s_rnd[33:16];
	assign s_cap = (s_mag > 18'd16384) ? 15'd16384 : s_mag[14:0];
	assign s_val = neg_q ? -$signed({1'b0, s_cap}) : $signed({1'b0, s_cap});

	// corner distance and march start
	logic signed [67:0] dd_w;
	logic [35:0]        dd_c;
	logic [PW-1:0]      px40, py40;
	assign dd_w = 68'(acc_q) + mp;
	assign dd_c = dd_w[35:0];
	assign px40 = PW'({px_q, 5'b0}) + PW'({px_q, 3'b0});
	assign py40 = PW'({py_q, 5'b0}) + PW'({py_q, 3'b0});

	// ceiling numerator
	logic [15:0] ceil_num;
	assign ceil_num = (dist_q > 8'd20) ? 16'(height_q) * 16'(dist_q - 8'd20) : 16'd0;

	// shade by distance quarters
	logic [9:0] d10, l10;
	logic [2:0] shade_c;
	assign d10 = 10'(dist_q);
	assign l10 = 10'(lim_eff);
	always_comb begin
		if (corner_q)                     shade_c = SHADE_BLANK;
		else if (10'(d10 * 10'd4) <= l10) shade_c = SHADE_FULL;
		else if (10'(d10 * 10'd3) < l10)  shade_c = SHADE_DARK;
		else if (10'(d10 * 10'd2) < l10)  shade_c = SHADE_MEDIUM;
		else if (d10 < l10)               shade_c = SHADE_LIGHT;
		else                              shade_c = SHADE_BLANK;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			fov_q    <= FOV_RST;
			steps_q  <= STEPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[9:0];
				CFG_HEIGHT: height_q <= cfg_data[7:0];
				CFG_FOV:    fov_q    <= cfg_data;
				CFG_STEPS:  steps_q  <= cfg_data[7:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	// wall map, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_SIZE; i++) map_q[i] <= '0;
		end else if (cmd.op == OP_LATCH && !item.action &&
			32'(item.row_index) < MAP_SIZE) begin
			map_q[item.row_index[IW-1:0]] <= item.row_walls[MAP_SIZE-1:0];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				col_q    <= item.column;
				px_q     <= item.player_x;
				py_q     <= item.player_y;
				pa_q     <= item.player_angle;
				off_q    <= 1'b0;
				corner_q <= 1'b0;
			end
			OP_OFF_MUL: begin
				quo_q <= mp[25:0];
				rem_q <= '0;
				dvs_q <= 11'(w_eff);
			end
			OP_DIV: begin
				rem_q <= rem_n;
				quo_q <= {quo_q[24:0], div_ge};
			end
			OP_ANGLE: begin
				ang_q <= pa_q - {1'b0, fov_q[15:1]} + quo_q[15:0];
			end
			OP_TRIG_T: begin
				t_q   <= t_c;
				neg_q <= ang_q[15];
				u2_q  <= {mp[28:0], 2'b00};
			end
			OP_TRIG_R: begin
				r_q <= poly_coef(cmd.idx) - mp[61:30];
			end
			OP_TRIG_S: begin
				if (!cmd.sel) begin
					ex_q  <= s_val;
					ang_q <= ang_q + 16'h4000;
				end else begin
					ey_q <= s_val;
				end
			end
			OP_M_INIT: begin
				xp_q <= $signed(px40) + PW'(ex_q);
				yp_q <= $signed(py40) + PW'(ey_q);
				k_q  <= 8'd1;
			end
			OP_MARCH: begin
				if (off_c) begin
					off_q  <= 1'b1;
					dist_q <= lim_eff;
				end else if (wall_c) begin
					dist_q <= k_q;
					cx_q   <= cx_c;
					cy_q   <= cy_c;
				end else if (k_q == lim_eff) begin
					dist_q <= lim_eff;
				end else begin
					xp_q <= xp_q + PW'(ex_q);
					yp_q <= yp_q + PW'(ey_q);
					k_q  <= k_q + 8'd1;
				end
			end
			OP_CRN_X: begin
				acc_q <= $signed(mp[39:0]);
				ay_q  <= ay_c;
				n0x_q <= n0x_q;
			end
			OP_CRN_Y: begin
				// stable insertion keeping the two nearest corners
				if (cmd.idx == 2'd0 || dd_c < n0d_q) begin
					n1x_q <= n0x_q;
					n1y_q <= n0y_q;
					n1d_q <= n0d_q;
					n0x_q <= ax_c;
					n0y_q <= ay_q;
					n0d_q <= dd_c;
				end else if (cmd.idx == 2'd1 || dd_c < n1d_q) begin
					n1x_q <= ax_c;
					n1y_q <= ay_q;
					n1d_q <= dd_c;
				end
			end
			OP_DOT_A: acc_q <= $signed(mp[39:0]);
			OP_DOT_B: dot_q <= acc_q + $signed(mp[39:0]);
			OP_CRS_A: acc_q <= $signed(mp[39:0]);
			OP_CRS_B: crs_q <= acc_q - $signed(mp[39:0]);
			OP_SQ_D:  sqd_q <= mp[51:0];
			OP_SQ_C:  sqc_q <= mp[51:0];
			OP_SCALE: begin
				scd_q <= 54'(sqd_q) * 54'd3;
				scc_q <= 67'(sqc_q) * 67'd29998;
			end
			OP_CMP: begin
				if (!dot_q[39] && dot_q != '0 && scc_q < 67'(scd_q)) corner_q <= 1'b1;
			end
			OP_CEIL: begin
				quo_q <= 26'(ceil_num);
				rem_q <= '0;
				dvs_q <= 11'({dist_q, 1'b0});
			end
			OP_FINISH: begin
				res_q.cast_column    <= col_q;
				res_q.distance_steps <= dist_q;
				res_q.ceiling_row    <= quo_q[6:0];
				res_q.floor_row      <= height_q - 8'(quo_q[6:0]);
				res_q.wall_shade     <= shade_c;
				res_q.corner_edge    <= corner_q;
				res_q.left_map       <= off_q;
			end
			default: begin
				col_q <= col_q;
			end
		endcase
	end

	assign result = res_q;

endmodule

`default_nettype wire

[src/grid_raycast_column_unit.sv]
// top level of the grid raycast column unit
// a load item writes one map row; a cast item runs the angle divide, the sine terms, the
// march loop of k steps and, when the ray hits a wall, a corner test, then the ceiling divide
// these passes of the shared restoring divider and the one-step-a-cycle march loop set
// the time of a cast; one item is in work at a time, a finished result waits in an
// output register while the next item is taken
// reset clears the wall map to all open and loads the register defaults
`default_nettype none

module grid_raycast_column_unit #(
	parameter int MAP_SIZE = grc_pkg::MAP_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  grc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output grc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import grc_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	grc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_cast    (item.action),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// datapath
	grc_datapath #(
		.MAP_SIZE (MAP_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// a load transfer never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && !item.action && !result_valid) |=> !result_valid)
		else $error("load item produced a result");

	// a cast transfer takes the unit busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.action) |=> !item_ready)
		else $error("unit ready right after a cast");

	// distance is never zero and floor lies below ceiling
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.distance_steps != 8'd0 &&
			result.floor_row >= 8'(result.ceiling_row)))
		else $error("bad distance or rows");

	// corner blanks the shade and never comes with leaving the map
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.corner_edge) |->
			(result.wall_shade == SHADE_BLANK && !result.left_map))
		else $error("corner flag inconsistent");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// testbench for the grid raycast column unit: directed table, then random casts against a predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import grc_pkg::*;

	localparam int MAP_N      = MAP_SIZE_DEF;
	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_WIDTH;
	logic [15:0] cfg_data = '0;

	grid_raycast_column_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] walls_pred [MAP_N];
	logic [9:0]  width_pred;
	logic [7:0]  height_pred;
	logic [15:0] fov_pred;
	logic [7:0]  depth_pred;

	result_t column_q [$];
	bit      failed;
	int      send_idle;
	int      recv_idle;
	bit      cur_typed;
	result_t cur_want;
	int      quiet_cycles;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	stim_row_t dir_rows [$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// quarter-wave sine, Q14
	function automatic longint unsigned quarter_sin(input int unsigned t);
		longint unsigned u, u2, r, s;
		u  = longint'(t) << 16;
		u2 = (u * u) >> 30;
		r  = 172271;
		r  = 64'd5026994 - ((u2 * r) >> 30);
		r  = 64'd85569306 - ((u2 * r) >> 30);
		r  = 64'd693598669 - ((u2 * r) >> 30);
		r  = 64'd1686629713 - ((u2 * r) >> 30);
		s  = (u * r) >> 30;
		s  = (s + 32768) >> 16;
		return (s > 16384) ? 64'd16384 : s;
	endfunction

	function automatic longint sin_q14(input logic [15:0] a);
		int unsigned t;
		longint m;
		t = a[13:0];
		if (a[14])
			t = 16384 - t;
		m = longint'(quarter_sin(t));
		return a[15] ? -m : m;
	endfunction

	// expected result of one cast
	function automatic result_t cast_column(input item_t it);
		result_t r;
		int unsigned w, lim, dist_k, off, shade, ceil_r;
		logic [15:0] ray;
		longint ex, ey, px, py, x, y, cx, cy, num, h, ax, ay, dd, dt, cr;
		longint ad, ac;
		longint vx [4], vy [4], d2 [4];
		bit off_map, corner;
		int j;
		w   = (width_pred == 0) ? 1 : width_pred;
		lim = (depth_pred == 0) ? 1 : depth_pred;
		h   = height_pred;
		px  = it.player_x;
		py  = it.player_y;
		off = (int'(it.column) * int'(fov_pred)) / w;
		ray = 16'(int'(it.player_angle) - int'(fov_pred >> 1) + off);
		ex  = sin_q14(ray);
		ey  = sin_q14(ray + 16'h4000);
		dist_k = lim;
		off_map = 1'b0;
		corner = 1'b0;
		for (int k = 1; k <= lim; k++) begin
			x = px * 40 + ex * k;
			y = py * 40 + ey * k;
			if (x < 0 || y < 0 || x / POS_UNIT >= MAP_N || y / POS_UNIT >= MAP_N) begin
				off_map = 1'b1;
				break;
			end
			cx = x / POS_UNIT;
			cy = y / POS_UNIT;
			if (!walls_pred[cy][cx])
				continue;
			dist_k = k;
			// stable sort of the four cell corners by distance
			for (int i = 0; i < 4; i++) begin
				ax = ((cx + (i >> 1)) << 12) - px;
				ay = ((cy + (i & 1)) << 12) - py;
				dd = ax * ax + ay * ay;
				for (j = i; j > 0 && d2[j - 1] > dd; j--) begin
					vx[j] = vx[j - 1];
					vy[j] = vy[j - 1];
					d2[j] = d2[j - 1];
				end
				vx[j] = ax;
				vy[j] = ay;
				d2[j] = dd;
			end
			for (int i = 0; i < 2; i++) begin
				dt = ex * vx[i] + ey * vy[i];
				cr = ex * vy[i] - ey * vx[i];
				if (dt > 0) begin
					ad = dt >>> 7;
					ac = ((cr < 0) ? -cr : cr) >>> 7;
					if (ac * ac * 29998 < ad * ad * 3)
						corner = 1'b1;
				end
			end
			break;
		end
		num = h * dist_k - 20 * h;
		ceil_r = (num > 0) ? int'(num / (2 * dist_k)) : 0;
		if (4 * dist_k <= lim)
			shade = SHADE_FULL;
		else if (3 * dist_k < lim)
			shade = SHADE_DARK;
		else if (2 * dist_k < lim)
			shade = SHADE_MEDIUM;
		else if (dist_k < lim)
			shade = SHADE_LIGHT;
		else
			shade = SHADE_BLANK;
		if (corner)
			shade = SHADE_BLANK;
		r.cast_column    = it.column;
		r.distance_steps = 8'(dist_k);
		r.ceiling_row    = 7'(ceil_r);
		r.floor_row      = 8'(int'(h) - ceil_r);
		r.wall_shade     = 3'(shade);
		r.corner_edge    = corner;
		r.left_map       = off_map;
		return r;
	endfunction

	// transfers on all channels: predictor update, checking, watchdog
	always @(posedge clk) begin
		result_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n && cfg_valid && cfg_ready) begin
			moved = 1'b1;
			case (cfg_index)
				CFG_WIDTH:  width_pred  = cfg_data[9:0];
				CFG_HEIGHT: height_pred = cfg_data[7:0];
				CFG_FOV:    fov_pred    = cfg_data;
				CFG_STEPS:  depth_pred  = cfg_data[7:0];
				default: ;
			endcase
		end
		if (arst_n && item_valid && item_ready) begin
			moved = 1'b1;
			if (!item.action)
				walls_pred[item.row_index] = item.row_walls;
			else
				column_q = {column_q, (cur_typed ? cur_want : cast_column(item))};
		end
		if (arst_n && result_valid && result_ready) begin
			moved = 1'b1;
			if (column_q.size() == 0) begin
				failed = 1'b1;
				$display("%t unexpected result %p", $realtime, result);
			end else begin
				want = column_q.pop_front();
				if (want.cast_column !== result.cast_column ||
						want.distance_steps !== result.distance_steps ||
						want.ceiling_row !== result.ceiling_row ||
						want.floor_row !== result.floor_row ||
						want.wall_shade !== result.wall_shade ||
						want.corner_edge !== result.corner_edge ||
						want.left_map !== result.left_map) begin
					failed = 1'b1;
					$display("%t expected %p actual %p", $realtime, want, result);
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("grid_raycast_column_unit: mismatch");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_idle);

	// one item transfer, entered and left at a falling edge
	task automatic send_item(input item_t it, input bit typed, input result_t want);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		cur_typed  = typed;
		cur_want   = want;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait for all results, then let an in-flight item finish
	task automatic drain();
		item_valid <= 1'b0;
		while (column_q.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	function automatic item_t load_row(input logic [3:0] r, input logic [15:0] w);
		item_t it;
		it = '0;
		it.row_index = r;
		it.row_walls = w;
		return it;
	endfunction

	function automatic item_t cast_item(input logic [9:0] c, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] a);
		item_t it;
		it = '0;
		it.action       = 1'b1;
		it.column       = c;
		it.player_x     = x;
		it.player_y     = y;
		it.player_angle = a;
		return it;
	endfunction

	function automatic logic [15:0] rand_walls();
		case ($urandom_range(4))
			0: return 16'($urandom & $urandom & $urandom);
			1: return 16'($urandom);
			2: return 16'h8001;
			3: return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom & $urandom);
		endcase
	endfunction

	function automatic item_t rand_cast();
		logic [9:0] c;
		if ($urandom_range(9) < 8 && width_pred > 1)
			c = 10'($urandom_range(width_pred - 1));
		else
			c = 10'($urandom);
		return cast_item(c, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	task automatic add_row(input item_t it, input bit typed, input result_t want);
		stim_row_t s;
		s.it    = it;
		s.typed = typed;
		s.want  = want;
		dir_rows = {dir_rows, s};
	endtask

	initial begin
		logic [15:0] phase_cfg [6][4];
		result_t lost;
		result_t none;
		item_t it;
		none = '0;
		failed = 1'b0;
		quiet_cycles = 0;
		send_idle = 19;
		recv_idle = 52;
		for (int i = 0; i < MAP_N; i++)
			walls_pred[i] = '0;
		width_pred  = WIDTH_RST;
		height_pred = HEIGHT_RST;
		fov_pred    = FOV_RST;
		depth_pred  = STEPS_RST;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty map, centered player: every ray leaves the map at full depth
		lost = '{cast_column: 10'd0, distance_steps: 8'd160, ceiling_row: 7'd17,
			floor_row: 8'd23, wall_shade: SHADE_BLANK, corner_edge: 1'b0, left_map: 1'b1};
		add_row(cast_item(10'd0, 16'h8000, 16'h8000, 16'h0000), 1'b1, lost);
		lost.cast_column = 10'd60;
		add_row(cast_item(10'd60, 16'h8000, 16'h8000, 16'hFFFF), 1'b1, lost);
		lost.cast_column = 10'd1023;
		add_row(cast_item(10'd1023, 16'h8000, 16'h8000, 16'h4000), 1'b1, lost);
		lost.cast_column = 10'd119;
		add_row(cast_item(10'd119, 16'h8000, 16'h8000, 16'hC000), 1'b1, lost);
		// extremes of the player position
		add_row(cast_item(10'd0, 16'h0000, 16'h0000, 16'h0000), 1'b0, none);
		add_row(cast_item(10'd5, 16'hFFFF, 16'hFFFF, 16'h8000), 1'b0, none);
		// walls: border rows, a single cell and the two border cells of a row
		add_row(load_row(4'd0, 16'hFFFF), 1'b0, none);
		add_row(load_row(4'd15, 16'hFFFF), 1'b0, none);
		add_row(load_row(4'd4, 16'h0010), 1'b0, none);
		add_row(load_row(4'd9, 16'h8001), 1'b0, none);
		add_row(cast_item(10'd60, 16'h8000, 16'h8000, 16'h8000), 1'b0, none);
		add_row(cast_item(10'd60, 16'h8000, 16'h8000, 16'h0000), 1'b0, none);
		add_row(cast_item(10'd60, 16'h8000, 16'h9800, 16'h4000), 1'b0, none);
		// diagonal ray straight at a cell corner
		add_row(cast_item(10'd60, 16'h2800, 16'h2800, 16'h2000), 1'b0, none);
		// player standing on the corner of a wall cell
		add_row(cast_item(10'd60, 16'h4000, 16'h4000, 16'h2000), 1'b0, none);
		add_row(cast_item(10'd30, 16'h4000, 16'h4000, 16'h2400), 1'b0, none);
		// wall right next to the player, short distance
		add_row(cast_item(10'd60, 16'h4800, 16'h3F00, 16'h0000), 1'b0, none);
		// column far past the width wraps the angle
		add_row(cast_item(10'd1023, 16'h7000, 16'h6000, 16'h1234), 1'b0, none);
		add_row(load_row(4'd4, 16'h0000), 1'b0, none);

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		drain();

		phase_cfg[0] = '{16'd120, 16'd40, 16'd8192, 16'd160};
		phase_cfg[1] = '{16'd1, 16'd254, 16'd65535, 16'd255};
		phase_cfg[2] = '{16'd0, 16'd2, 16'd1, 16'd0};
		phase_cfg[3] = '{16'd1023, 16'd255, 16'd32768, 16'd40};
		phase_cfg[4] = '{16'd64, 16'd100, 16'd12000, 16'd20};
		phase_cfg[5] = '{16'($urandom_range(1, 1023)), 16'($urandom_range(2, 254)),
			16'($urandom_range(1, 65535)), 16'($urandom_range(1, 120))};

		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					send_idle = 19;
					recv_idle = 52;
				end
				1: begin
					send_idle = 52;
					recv_idle = 19;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			if (p > 0) begin
				write_reg(CFG_WIDTH, phase_cfg[p][0]);
				write_reg(CFG_HEIGHT, phase_cfg[p][1]);
				write_reg(CFG_FOV, phase_cfg[p][2]);
				write_reg(CFG_STEPS, phase_cfg[p][3]);
			end
			// fresh map first, then mixed loads and casts
			for (int r = 0; r < MAP_N; r++)
				send_item(load_row(4'(r), (r == 0 || r == MAP_N - 1) ? 16'hFFFF :
					(rand_walls() | 16'h8001)), 1'b0, none);
			for (int n = 0; n < 250; n++) begin
				if ($urandom_range(9) < 2)
					it = load_row(4'($urandom), rand_walls());
				else
					it = rand_cast();
				send_item(it, 1'b0, none);
			end
			drain();
		end

		if (!failed)
			$display("grid_raycast_column_unit: match");
		else
			$display("grid_raycast_column_unit: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
